@@ rtl/core/pmpf_pkg.sv @@
// Package for the paced multichannel packet FIFO: sizes, codes, request and
// result types, controller states and the controller/datapath interface.
// Depends on nothing.
`default_nettype none
package pmpf_pkg;

    localparam int CHANNELS      = 2;
    localparam int QUEUE_DEPTH   = 4;
    localparam int PAYLOAD_BYTES = 32;
    localparam int MAX_RESULTS   = 64;
    localparam int RINGS         = 2 * CHANNELS;
    localparam int SLOTS         = RINGS * QUEUE_DEPTH;
    localparam int MEM_DEPTH     = SLOTS * PAYLOAD_BYTES;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RW = $clog2(RINGS);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int SW = $clog2(SLOTS);
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int FW = $clog2(PAYLOAD_BYTES + 1);
    localparam int BW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int KW = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] CMD_PUSH_RX = 2'd0;
    localparam logic [1:0] CMD_POP_RX  = 2'd1;
    localparam logic [1:0] CMD_PUSH_TX = 2'd2;
    localparam logic [1:0] CMD_TICK    = 2'd3;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [1:0] STATUS_BAD_CH = 2'd3;

    localparam logic [1:0] KIND_ACK = 2'd0;
    localparam logic [1:0] KIND_RX  = 2'd1;
    localparam logic [1:0] KIND_TX  = 2'd2;

    localparam logic [7:0] SEND_INTERVAL_RESET = 8'd10;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  channel;
        logic [7:0]  data_byte;
        logic        byte_last;
        logic [15:0] packet_timeout;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [1:0]  out_channel;
        logic [7:0]  out_byte;
        logic [15:0] out_timeout;
        logic        out_last;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_STREAM
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_ACK_BAD,
        OP_ACK_EMPTY,
        OP_PUSH,
        OP_POP_SETUP,
        OP_TICK_INIT,
        OP_TICK_CH,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic is_tick;
        logic is_push;
        logic bad_ch;
        logic ring_empty;
        logic tx_go;
        logic len_zero;
        logic last_byte;
        logic last_ch;
    } stat_t;

    function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] s);
        logic [QW-1:0] r;
        if (32'(s) + 32'd1 >= 32'(QUEUE_DEPTH))
            r = '0;
        else
            r = s + QW'(1);
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/pmpf_ctrl.sv @@
// Controller state machine of the paced multichannel packet FIFO.
// Depends on pmpf_pkg; drives commands to pmpf_dp and reads its status.
`default_nettype none
module pmpf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  pmpf_pkg::stat_t     st,
    output pmpf_pkg::ctrl_t     ctrl
);

    pmpf_pkg::state_t state_reg;
    pmpf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pmpf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pmpf_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = pmpf_pkg::ST_DECODE;
            end
            pmpf_pkg::ST_DECODE:
            begin
                if (st.is_tick)
                    state_next = pmpf_pkg::ST_TICK;
                else if (st.bad_ch || st.is_push || st.ring_empty || st.len_zero)
                    state_next = pmpf_pkg::ST_IDLE;
                else
                    state_next = pmpf_pkg::ST_STREAM;
            end
            pmpf_pkg::ST_TICK:
            begin
                if (st.tx_go && !st.len_zero)
                    state_next = pmpf_pkg::ST_STREAM;
                else if (st.last_ch)
                    state_next = pmpf_pkg::ST_IDLE;
            end
            pmpf_pkg::ST_STREAM:
            begin
                if (st.last_byte)
                begin
                    if (st.is_tick && !st.last_ch)
                        state_next = pmpf_pkg::ST_TICK;
                    else
                        state_next = pmpf_pkg::ST_IDLE;
                end
            end
            default: state_next = pmpf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.op = pmpf_pkg::OP_NONE;
        case (state_reg)
            pmpf_pkg::ST_IDLE:
            begin
                if (start)
                    ctrl.op = pmpf_pkg::OP_LATCH;
            end
            pmpf_pkg::ST_DECODE:
            begin
                if (st.is_tick)
                    ctrl.op = pmpf_pkg::OP_TICK_INIT;
                else if (st.bad_ch)
                    ctrl.op = pmpf_pkg::OP_ACK_BAD;
                else if (st.is_push)
                    ctrl.op = pmpf_pkg::OP_PUSH;
                else if (st.ring_empty)
                    ctrl.op = pmpf_pkg::OP_ACK_EMPTY;
                else
                    ctrl.op = pmpf_pkg::OP_POP_SETUP;
            end
            pmpf_pkg::ST_TICK:   ctrl.op = pmpf_pkg::OP_TICK_CH;
            pmpf_pkg::ST_STREAM: ctrl.op = pmpf_pkg::OP_READ;
            default:             ctrl.op = pmpf_pkg::OP_NONE;
        endcase
    end

    assign busy = (state_reg != pmpf_pkg::ST_IDLE);

endmodule
`default_nettype wire

@@ rtl/core/pmpf_dp.sv @@
// Datapath of the paced multichannel packet FIFO: ring pointers, slot
// tables, payload memory, interval timers and the result register.
// Depends on pmpf_pkg; commanded by pmpf_ctrl.
`default_nettype none
module pmpf_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  pmpf_pkg::req_t      req,
    input  wire logic           cfg_we,
    input  wire logic [7:0]     cfg_data,
    input  pmpf_pkg::ctrl_t     ctrl,
    output pmpf_pkg::stat_t     st,
    output pmpf_pkg::res_t      result,
    output logic                result_valid
);

    logic [pmpf_pkg::QW-1:0] head_reg  [pmpf_pkg::RINGS];
    logic [pmpf_pkg::QW-1:0] tail_reg  [pmpf_pkg::RINGS];
    logic                    empty_reg [pmpf_pkg::RINGS];
    logic [pmpf_pkg::FW-1:0] fill_reg  [pmpf_pkg::RINGS];
    logic [7:0]              timer_reg [pmpf_pkg::CHANNELS];
    logic [pmpf_pkg::FW-1:0] slot_len_reg [pmpf_pkg::SLOTS];
    logic [15:0]             slot_tmo_reg [pmpf_pkg::SLOTS];
    logic [7:0]              mem [pmpf_pkg::MEM_DEPTH];

    logic [7:0]              interval_reg;
    pmpf_pkg::req_t          req_reg;
    logic [pmpf_pkg::CW-1:0] tick_ch_reg;
    logic [pmpf_pkg::KW-1:0] k_reg;
    logic [pmpf_pkg::BW-1:0] byte_idx_reg;
    logic [pmpf_pkg::SW-1:0] s_base_reg;
    logic [pmpf_pkg::FW-1:0] s_len_reg;
    logic [15:0]             s_tmo_reg;
    logic [1:0]              s_kind_reg;
    logic [1:0]              s_ch_reg;
    logic [7:0]              mem_q_reg;
    logic                    res_valid_reg;
    logic                    res_ack_reg;
    logic [1:0]              res_status_reg;
    logic [1:0]              res_kind_reg;
    logic [1:0]              res_ch_reg;
    logic [15:0]             res_tmo_reg;
    logic                    res_last_reg;

    logic                    is_tick;
    logic                    is_push;
    logic                    bad_ch;
    logic [pmpf_pkg::CW-1:0] chi;
    logic [pmpf_pkg::RW-1:0] rsel;
    logic [pmpf_pkg::QW-1:0] hd;
    logic [pmpf_pkg::QW-1:0] tl;
    logic                    sel_empty;
    logic [pmpf_pkg::SW-1:0] head_base;
    logic [pmpf_pkg::FW-1:0] len_raw;
    logic [pmpf_pkg::FW-1:0] len;
    logic [15:0]             head_tmo;
    logic [15:0]             tmo_clamped;
    logic [7:0]              t_cur;
    logic [7:0]              t_inc;
    logic                    tx_go;
    logic                    full;
    logic [pmpf_pkg::QW-1:0] pslot;
    logic [pmpf_pkg::SW-1:0] pbase;
    logic [pmpf_pkg::FW-1:0] fill_cur;
    logic                    fill_room;
    logic [pmpf_pkg::FW-1:0] fill_after;
    logic                    do_setup;
    logic                    last_byte;
    logic                    last_ch;
    logic                    mem_we;
    logic [pmpf_pkg::AW-1:0] waddr;
    logic [pmpf_pkg::AW-1:0] raddr;
    logic [pmpf_pkg::KW:0]   k_sum;

    assign is_tick = (req_reg.cmd == pmpf_pkg::CMD_TICK);
    assign is_push = (req_reg.cmd == pmpf_pkg::CMD_PUSH_RX) ||
                     (req_reg.cmd == pmpf_pkg::CMD_PUSH_TX);
    assign bad_ch  = (32'(req_reg.channel) >= 32'(pmpf_pkg::CHANNELS));
    assign chi     = pmpf_pkg::CW'(req_reg.channel);

    always_comb
    begin
        if (is_tick)
            rsel = pmpf_pkg::RW'(pmpf_pkg::CHANNELS) + pmpf_pkg::RW'(tick_ch_reg);
        else if (req_reg.cmd == pmpf_pkg::CMD_PUSH_TX)
            rsel = pmpf_pkg::RW'(pmpf_pkg::CHANNELS) + pmpf_pkg::RW'(chi);
        else
            rsel = pmpf_pkg::RW'(chi);
    end

    assign hd        = head_reg[rsel];
    assign tl        = tail_reg[rsel];
    assign sel_empty = empty_reg[rsel];
    assign head_base = pmpf_pkg::SW'(rsel) * pmpf_pkg::SW'(pmpf_pkg::QUEUE_DEPTH)
                       + pmpf_pkg::SW'(hd);
    assign len_raw   = slot_len_reg[head_base];
    assign len       = (32'(len_raw) > 32'(pmpf_pkg::PAYLOAD_BYTES)) ?
                       pmpf_pkg::FW'(pmpf_pkg::PAYLOAD_BYTES) : len_raw;
    assign head_tmo  = slot_tmo_reg[head_base];
    assign tmo_clamped = (head_tmo > {8'd0, interval_reg}) ? {8'd0, interval_reg} : head_tmo;

    assign t_cur = timer_reg[tick_ch_reg];
    assign t_inc = (t_cur == 8'hFF) ? t_cur : t_cur + 8'd1;
    assign k_sum = (pmpf_pkg::KW + 1)'(k_reg) + (pmpf_pkg::KW + 1)'(len);
    assign tx_go = !sel_empty && (t_inc >= interval_reg) &&
                   (32'(k_sum) <= 32'(pmpf_pkg::MAX_RESULTS));

    assign full       = !sel_empty && (pmpf_pkg::next_slot(tl) == hd);
    assign pslot      = sel_empty ? '0 : pmpf_pkg::next_slot(tl);
    assign pbase      = pmpf_pkg::SW'(rsel) * pmpf_pkg::SW'(pmpf_pkg::QUEUE_DEPTH)
                        + pmpf_pkg::SW'(pslot);
    assign fill_cur   = fill_reg[rsel];
    assign fill_room  = (32'(fill_cur) < 32'(pmpf_pkg::PAYLOAD_BYTES));
    assign fill_after = fill_room ? fill_cur + pmpf_pkg::FW'(1) : fill_cur;

    assign do_setup  = (ctrl.op == pmpf_pkg::OP_POP_SETUP) ||
                       ((ctrl.op == pmpf_pkg::OP_TICK_CH) && tx_go);
    assign last_byte = (pmpf_pkg::FW'(byte_idx_reg) + pmpf_pkg::FW'(1) == s_len_reg);
    assign last_ch   = (tick_ch_reg == pmpf_pkg::CW'(pmpf_pkg::CHANNELS - 1));

    assign mem_we = (ctrl.op == pmpf_pkg::OP_PUSH) && !full && fill_room;
    assign waddr  = pmpf_pkg::AW'(pbase) * pmpf_pkg::AW'(pmpf_pkg::PAYLOAD_BYTES)
                    + pmpf_pkg::AW'(fill_cur);
    assign raddr  = pmpf_pkg::AW'(s_base_reg) * pmpf_pkg::AW'(pmpf_pkg::PAYLOAD_BYTES)
                    + pmpf_pkg::AW'(byte_idx_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= req_reg.data_byte;
        if (ctrl.op == pmpf_pkg::OP_READ)
            mem_q_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= pmpf_pkg::SEND_INTERVAL_RESET;
            tick_ch_reg   <= '0;
            k_reg         <= '0;
            byte_idx_reg  <= '0;
            res_valid_reg <= 1'b0;
            for (int r = 0; r < pmpf_pkg::RINGS; r++)
            begin
                head_reg[r]  <= '0;
                tail_reg[r]  <= '0;
                empty_reg[r] <= 1'b1;
                fill_reg[r]  <= '0;
            end
            for (int c = 0; c < pmpf_pkg::CHANNELS; c++)
                timer_reg[c] <= '0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            if (cfg_we)
                interval_reg <= cfg_data;
            if (do_setup)
            begin
                byte_idx_reg <= '0;
                if (hd == tl)
                    empty_reg[rsel] <= 1'b1;
                else
                    head_reg[rsel] <= pmpf_pkg::next_slot(hd);
            end
            case (ctrl.op)
                pmpf_pkg::OP_ACK_BAD,
                pmpf_pkg::OP_ACK_EMPTY:
                    res_valid_reg <= 1'b1;
                pmpf_pkg::OP_PUSH:
                begin
                    res_valid_reg <= 1'b1;
                    if (req_reg.byte_last)
                    begin
                        fill_reg[rsel] <= '0;
                        if (!full)
                        begin
                            tail_reg[rsel] <= pslot;
                            if (sel_empty)
                            begin
                                head_reg[rsel]  <= '0;
                                empty_reg[rsel] <= 1'b0;
                            end
                        end
                    end
                    else
                        fill_reg[rsel] <= fill_after;
                end
                pmpf_pkg::OP_TICK_INIT:
                begin
                    tick_ch_reg <= '0;
                    k_reg       <= '0;
                end
                pmpf_pkg::OP_TICK_CH:
                begin
                    timer_reg[tick_ch_reg] <= tx_go ? 8'd0 : t_inc;
                    if (tx_go)
                        k_reg <= pmpf_pkg::KW'(k_sum);
                    if (!(tx_go && len != '0))
                        tick_ch_reg <= tick_ch_reg + pmpf_pkg::CW'(1);
                end
                pmpf_pkg::OP_READ:
                begin
                    res_valid_reg <= 1'b1;
                    if (last_byte)
                    begin
                        byte_idx_reg <= '0;
                        if (s_kind_reg == pmpf_pkg::KIND_TX)
                            tick_ch_reg <= tick_ch_reg + pmpf_pkg::CW'(1);
                    end
                    else
                        byte_idx_reg <= byte_idx_reg + pmpf_pkg::BW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == pmpf_pkg::OP_LATCH)
            req_reg <= req;
        if ((ctrl.op == pmpf_pkg::OP_PUSH) && req_reg.byte_last && !full)
        begin
            slot_len_reg[pbase] <= fill_after;
            slot_tmo_reg[pbase] <= req_reg.packet_timeout;
        end
        if (do_setup)
        begin
            s_base_reg <= head_base;
            s_len_reg  <= len;
            s_tmo_reg  <= is_tick ? tmo_clamped : head_tmo;
            s_kind_reg <= is_tick ? pmpf_pkg::KIND_TX : pmpf_pkg::KIND_RX;
            s_ch_reg   <= is_tick ? 2'(tick_ch_reg) : req_reg.channel;
        end
        case (ctrl.op)
            pmpf_pkg::OP_ACK_BAD,
            pmpf_pkg::OP_ACK_EMPTY,
            pmpf_pkg::OP_PUSH:
            begin
                res_ack_reg    <= 1'b1;
                res_kind_reg   <= pmpf_pkg::KIND_ACK;
                res_ch_reg     <= req_reg.channel;
                res_tmo_reg    <= '0;
                res_last_reg   <= 1'b1;
                if (ctrl.op == pmpf_pkg::OP_ACK_BAD)
                    res_status_reg <= pmpf_pkg::STATUS_BAD_CH;
                else if (ctrl.op == pmpf_pkg::OP_ACK_EMPTY)
                    res_status_reg <= pmpf_pkg::STATUS_EMPTY;
                else
                    res_status_reg <= full ? pmpf_pkg::STATUS_FULL : pmpf_pkg::STATUS_OK;
            end
            pmpf_pkg::OP_READ:
            begin
                res_ack_reg    <= 1'b0;
                res_status_reg <= pmpf_pkg::STATUS_OK;
                res_kind_reg   <= s_kind_reg;
                res_ch_reg     <= s_ch_reg;
                res_tmo_reg    <= s_tmo_reg;
                res_last_reg   <= last_byte;
            end
            default:
            begin
            end
        endcase
    end

    assign st.is_tick    = is_tick;
    assign st.is_push    = is_push;
    assign st.bad_ch     = bad_ch;
    assign st.ring_empty = sel_empty;
    assign st.tx_go      = tx_go;
    assign st.len_zero   = (len == '0);
    assign st.last_byte  = last_byte;
    assign st.last_ch    = last_ch;

    assign result_valid       = res_valid_reg;
    assign result.status      = res_status_reg;
    assign result.kind        = res_kind_reg;
    assign result.out_channel = res_ch_reg;
    assign result.out_byte    = res_ack_reg ? 8'd0 : mem_q_reg;
    assign result.out_timeout = res_tmo_reg;
    assign result.out_last    = res_last_reg;

`ifndef SYNTH
    a_read_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == pmpf_pkg::OP_READ) |=> (res_valid_reg && !res_ack_reg))
        else $error("payload read did not produce a result");
    a_push_acks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == pmpf_pkg::OP_PUSH) |=>
        (res_valid_reg && res_kind_reg == pmpf_pkg::KIND_ACK && res_last_reg))
        else $error("push did not produce an acknowledge");
    a_stream_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ack_reg) |-> (res_status_reg == pmpf_pkg::STATUS_OK))
        else $error("packet byte carries an error status");
    a_budget: assert property (@(posedge clk) disable iff (!rst_n)
        32'(k_reg) <= 32'(pmpf_pkg::MAX_RESULTS))
        else $error("tick result budget exceeded");
`endif

endmodule
`default_nettype wire

@@ rtl/core/paced_multichannel_packet_fifo_top.sv @@
// Top level of the paced multichannel packet FIFO: controller plus datapath.
// Depends on pmpf_pkg, pmpf_ctrl and pmpf_dp.
// A push holds busy while it is decoded, then strobes a one-cycle registered acknowledge,
// and the next request is taken once busy is low again. A pop holds busy through decode and
// its payload stream and strobes one byte per cycle; a tick holds busy through decode, a check
// of each channel and the stream of every byte it sends. Results are never stalled. Reset is
// asynchronous and empties every ring, clears timers, sets the interval to 10.
`default_nettype none
module paced_multichannel_packet_fifo_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  pmpf_pkg::req_t  req,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data,
    output pmpf_pkg::res_t  result,
    output logic            result_valid
);

    pmpf_pkg::ctrl_t ctrl;
    pmpf_pkg::stat_t st;

    pmpf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .ctrl  (ctrl)
    );

    pmpf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .ctrl         (ctrl),
        .st           (st),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
`default_nettype wire
